// File: rtl/rht_pkg.sv
package rht_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam logic [15:0] NO_HANDLE = 16'hFFFF;
   localparam logic [31:0] SIZE_LIMIT_RESET = 32'hFFFF_FFFF;

   // commands
   localparam logic [1:0] CMD_UPLOAD  = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_QUERY   = 2'd2;
   localparam logic [1:0] CMD_STOP    = 2'd3;

   // result status codes
   localparam logic [3:0] ST_NEW       = 4'd0;
   localparam logic [3:0] ST_SHARED    = 4'd1;
   localparam logic [3:0] ST_FREED     = 4'd2;
   localparam logic [3:0] ST_BUDGET    = 4'd3;
   localparam logic [3:0] ST_FULL      = 4'd4;
   localparam logic [3:0] ST_INVALID   = 4'd5;
   localparam logic [3:0] ST_STALE     = 4'd6;
   localparam logic [3:0] ST_STOPPED   = 4'd7;
   localparam logic [3:0] ST_REF_LIMIT = 4'd8;
   localparam logic [3:0] ST_IGNORED   = 4'd9;
   localparam logic [3:0] ST_STOP_ENT  = 4'd10;
   localparam logic [3:0] ST_STOP_DONE = 4'd11;

   // register indexes
   localparam logic [0:0] REG_BUDGET = 1'd0;
   localparam logic [0:0] REG_LIMIT  = 1'd1;

   // one result item
   typedef struct packed {
      logic [3:0]  status;
      logic [4:0]  slot;
      logic [31:0] gen;
      logic [15:0] handle;
      logic [15:0] refs;
      logic [31:0] total;
      logic [5:0]  live;
      logic        last;
   } rsp_type;

endpackage

// File: rtl/refcounted_handle_table_unit.sv
// Channel  Ports                          Direction  Transfer when
// req      req_valid/req_stall/req_*      in         req_valid && !req_stall
// rsp      rsp_valid/rsp_stall/rsp_*      out        rsp_valid && !rsp_stall
// csr      csr_psel/penable/pwrite/...    in         psel && penable && pwrite
// Upload: accept, scan of every slot, allocate, result transfer.
// Release and query: accept, token check, result transfer.
// Stop: accept, a walk over all slots with a result transfer per live slot, done step, final transfer.
// Reset clears the FSM, counters, CSRs and slot state at once; key memory is not cleared.
// A stalled result holds the sequencer; no new request is taken meanwhile.
module refcounted_handle_table_unit #(
   parameter int SLOTS = rht_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_key_hash,
   input  logic [31:0] req_size_bytes,
   input  logic [15:0] req_gpu_handle,
   input  logic [7:0]  req_slot_index,
   input  logic [31:0] req_generation,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_status,
   output logic [4:0]  rsp_slot_index_res,
   output logic [31:0] rsp_generation_res,
   output logic [15:0] rsp_gpu_handle_res,
   output logic [15:0] rsp_references,
   output logic [31:0] rsp_total_bytes,
   output logic [5:0]  rsp_live_count,
   output logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ALLOC = 3'd2;
   localparam logic [2:0] S_TOKEN = 3'd3;
   localparam logic [2:0] S_STOP  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [63:0] key_mem [SLOTS];
   logic [31:0] gen_ff [SLOTS];
   logic [15:0] refs_ff [SLOTS];
   logic [31:0] size_ff [SLOTS];
   logic [15:0] hnd_ff [SLOTS];

   logic [2:0]    state_ff;
   logic [CW-1:0] idx_ff;
   logic [CW-1:0] live_ff;
   logic          alive_ff, stop_tail_ff, match_ff, free_ok_ff;
   logic [IW-1:0] match_idx_ff, free_idx_ff;
   logic [31:0]   used_ff, next_gen_ff, budget_ff, limit_ff;
   logic [1:0]    cmd_ff;
   logic [63:0]   key_ff;
   logic [31:0]   rsize_ff, rgen_ff;
   logic [15:0]   rhnd_ff;
   logic [7:0]    rslot_ff;
   logic [63:0]   key_rd_ff;
   logic          valid_ff;
   rht_pkg::rsp_type out_ff;

   logic [IW-1:0] cur;
   logic [IW-1:0] tok;
   logic          tok_ok;
   logic [31:0]   remaining;
   logic          csr_wr;

   assign cur = idx_ff[IW-1:0];
   assign tok = rslot_ff[IW-1:0];
   assign tok_ok = ({24'd0, rslot_ff} < 32'(SLOTS));
   assign remaining = (budget_ff > used_ff) ? budget_ff - used_ff : 32'd0;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   assign req_stall = (state_ff != S_IDLE);
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == rht_pkg::REG_LIMIT) ? limit_ff : budget_ff;

   assign rsp_valid = valid_ff;
   assign rsp_status = out_ff.status;
   assign rsp_slot_index_res = out_ff.slot;
   assign rsp_generation_res = out_ff.gen;
   assign rsp_gpu_handle_res = out_ff.handle;
   assign rsp_references = out_ff.refs;
   assign rsp_total_bytes = out_ff.total;
   assign rsp_live_count = out_ff.live;
   assign rsp_last = out_ff.last;

   // key memory: one read port feeding the shared compare
   always_ff @(posedge clock) begin
      if (state_ff == S_ALLOC && free_ok_ff && match_ff == 1'b0 &&
          rsize_ff <= limit_ff && rsize_ff <= remaining && rhnd_ff != rht_pkg::NO_HANDLE)
         key_mem[free_idx_ff] <= key_ff;
      key_rd_ff <= key_mem[cur];
   end

   // sequencer
   always_ff @(posedge clock) begin
      rht_pkg::rsp_type r;
      r = '{status: rht_pkg::ST_IGNORED, slot: 5'd0, gen: 32'd0,
            handle: rht_pkg::NO_HANDLE, refs: 16'd0, total: used_ff,
            live: 6'(live_ff), last: 1'b1};
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         alive_ff <= 1'b1;
         used_ff <= '0;
         next_gen_ff <= 32'd1;
         live_ff <= '0;
         budget_ff <= '0;
         limit_ff <= rht_pkg::SIZE_LIMIT_RESET;
         idx_ff <= '0;
         stop_tail_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            gen_ff[i] <= '0;
            refs_ff[i] <= '0;
            size_ff[i] <= '0;
            hnd_ff[i] <= rht_pkg::NO_HANDLE;
         end
      end else begin
         if (csr_wr) begin
            if (csr_paddr[2] == rht_pkg::REG_BUDGET) budget_ff <= csr_pwdata;
            else limit_ff <= csr_pwdata;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  cmd_ff <= req_command;
                  key_ff <= req_key_hash;
                  rsize_ff <= req_size_bytes;
                  rhnd_ff <= req_gpu_handle;
                  rslot_ff <= req_slot_index;
                  rgen_ff <= req_generation;
                  idx_ff <= '0;
                  match_ff <= 1'b0;
                  free_ok_ff <= 1'b0;
                  stop_tail_ff <= 1'b0;
                  case (req_command)
                     rht_pkg::CMD_UPLOAD: begin
                        if (!alive_ff) begin
                           r.status = rht_pkg::ST_STOPPED;
                           out_ff <= r;
                           valid_ff <= 1'b1;
                           state_ff <= S_OUT;
                        end else state_ff <= S_SCAN;
                     end
                     rht_pkg::CMD_STOP: begin
                        if (!alive_ff) begin
                           out_ff <= r;
                           valid_ff <= 1'b1;
                           state_ff <= S_OUT;
                        end else state_ff <= S_STOP;
                     end
                     default: state_ff <= S_TOKEN;
                  endcase
               end
            end
            // one slot per cycle; the key read is registered, so it belongs to the previous index
            S_SCAN: begin
               if (idx_ff != '0) begin
                  if (!match_ff && refs_ff[cur - IW'(1)] != 16'd0 && key_rd_ff == key_ff) begin
                     match_ff <= 1'b1;
                     match_idx_ff <= cur - IW'(1);
                  end
                  if (!free_ok_ff && refs_ff[cur - IW'(1)] == 16'd0) begin
                     free_ok_ff <= 1'b1;
                     free_idx_ff <= cur - IW'(1);
                  end
               end
               if (idx_ff == CW'(SLOTS)) state_ff <= S_ALLOC;
               else idx_ff <= idx_ff + CW'(1);
            end
            S_ALLOC: begin
               if (match_ff) begin
                  if (refs_ff[match_idx_ff] == 16'hFFFF) begin
                     r.status = rht_pkg::ST_REF_LIMIT;
                     r.refs = 16'hFFFF;
                  end else begin
                     r.status = rht_pkg::ST_SHARED;
                     r.refs = refs_ff[match_idx_ff] + 16'd1;
                     refs_ff[match_idx_ff] <= refs_ff[match_idx_ff] + 16'd1;
                  end
                  r.slot = 5'(match_idx_ff);
                  r.gen = gen_ff[match_idx_ff];
                  r.handle = hnd_ff[match_idx_ff];
               end else if (rsize_ff > limit_ff || rsize_ff > remaining) begin
                  r.status = rht_pkg::ST_BUDGET;
               end else if (!free_ok_ff) begin
                  r.status = rht_pkg::ST_FULL;
               end else if (rhnd_ff == rht_pkg::NO_HANDLE) begin
                  r.status = rht_pkg::ST_INVALID;
               end else begin
                  gen_ff[free_idx_ff] <= next_gen_ff;
                  refs_ff[free_idx_ff] <= 16'd1;
                  size_ff[free_idx_ff] <= rsize_ff;
                  hnd_ff[free_idx_ff] <= rhnd_ff;
                  used_ff <= used_ff + rsize_ff;
                  live_ff <= live_ff + CW'(1);
                  next_gen_ff <= (next_gen_ff == 32'hFFFF_FFFF) ? 32'd1 : next_gen_ff + 32'd1;
                  r = '{status: rht_pkg::ST_NEW, slot: 5'(free_idx_ff), gen: next_gen_ff,
                        handle: rhnd_ff, refs: 16'd1, total: used_ff + rsize_ff,
                        live: 6'(live_ff + CW'(1)), last: 1'b1};
               end
               out_ff <= r;
               valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            S_TOKEN: begin
               if (cmd_ff == rht_pkg::CMD_QUERY) begin
                  if (!alive_ff || !tok_ok) r.status = rht_pkg::ST_INVALID;
                  else if (refs_ff[tok] == 16'd0 || gen_ff[tok] != rgen_ff)
                     r.status = rht_pkg::ST_STALE;
                  else begin
                     r.status = rht_pkg::ST_SHARED;
                     r.slot = 5'(tok);
                     r.gen = gen_ff[tok];
                     r.handle = hnd_ff[tok];
                     r.refs = refs_ff[tok];
                  end
               end else if (alive_ff && tok_ok && refs_ff[tok] != 16'd0 &&
                            gen_ff[tok] == rgen_ff) begin
                  r.slot = 5'(tok);
                  r.gen = gen_ff[tok];
                  refs_ff[tok] <= refs_ff[tok] - 16'd1;
                  if (refs_ff[tok] != 16'd1) begin
                     r.status = rht_pkg::ST_SHARED;
                     r.handle = hnd_ff[tok];
                     r.refs = refs_ff[tok] - 16'd1;
                  end else begin
                     r.status = rht_pkg::ST_FREED;
                     r.handle = hnd_ff[tok];
                     r.total = used_ff - size_ff[tok];
                     r.live = 6'(live_ff - CW'(1));
                     used_ff <= used_ff - size_ff[tok];
                     live_ff <= live_ff - CW'(1);
                     size_ff[tok] <= '0;
                     hnd_ff[tok] <= rht_pkg::NO_HANDLE;
                  end
               end
               out_ff <= r;
               valid_ff <= 1'b1;
               state_ff <= S_OUT;
            end
            // walk slots; emit one entry per live slot, then the done result
            S_STOP: begin
               if (idx_ff == CW'(SLOTS)) begin
                  r.status = rht_pkg::ST_STOP_DONE;
                  r.total = 32'd0;
                  r.live = 6'd0;
                  used_ff <= '0;
                  live_ff <= '0;
                  alive_ff <= 1'b0;
                  stop_tail_ff <= 1'b1;
                  out_ff <= r;
                  valid_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else begin
                  size_ff[cur] <= '0;
                  if (refs_ff[cur] != 16'd0) begin
                     r = '{status: rht_pkg::ST_STOP_ENT, slot: 5'(cur), gen: gen_ff[cur],
                           handle: hnd_ff[cur], refs: 16'd0, total: 32'd0,
                           live: 6'd0, last: 1'b0};
                     refs_ff[cur] <= '0;
                     hnd_ff[cur] <= rht_pkg::NO_HANDLE;
                     out_ff <= r;
                     valid_ff <= 1'b1;
                     state_ff <= S_OUT;
                  end
                  idx_ff <= idx_ff + CW'(1);
               end
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  valid_ff <= 1'b0;
                  state_ff <= (cmd_ff == rht_pkg::CMD_STOP && alive_ff && !stop_tail_ff) ?
                              S_STOP : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// File: tb/sv/rht_checker.sv
module rht_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [63:0] req_key_hash,
   input  logic [31:0] req_size_bytes,
   input  logic [15:0] req_gpu_handle,
   input  logic [7:0]  req_slot_index,
   input  logic [31:0] req_generation,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [3:0]  rsp_status,
   input  logic [4:0]  rsp_slot_index_res,
   input  logic [31:0] rsp_generation_res,
   input  logic [15:0] rsp_gpu_handle_res,
   input  logic [15:0] rsp_references,
   input  logic [31:0] rsp_total_bytes,
   input  logic [5:0]  rsp_live_count,
   input  logic        rsp_last,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rht_pkg::*;

   localparam int NSLOT = 32;

   // shadow of the table
   logic [63:0] tbl_key [NSLOT];
   logic [31:0] tbl_gen [NSLOT];
   logic [15:0] tbl_refs [NSLOT];
   logic [31:0] tbl_size [NSLOT];
   logic [15:0] tbl_handle [NSLOT];
   logic [31:0] bytes_used, gen_next, budget, limit;
   logic        alive;

   rsp_type expected_rsp [$];

   function automatic logic [5:0] live_slots();
      logic [5:0] n;
      n = 0;
      for (int i = 0; i < NSLOT; i++) if (tbl_refs[i] != 0) n++;
      return n;
   endfunction

   function automatic void push_rsp(logic [3:0] st, int s, logic [31:0] g,
                                    logic [15:0] h, logic [15:0] r, logic lst);
      rsp_type e;
      e.status = st;
      e.slot = s[4:0];
      e.gen = g;
      e.handle = h;
      e.refs = r;
      e.total = bytes_used;
      e.live = live_slots();
      e.last = lst;
      expected_rsp.push_back(e);
   endfunction

   function automatic void push_slot(logic [3:0] st, int i);
      push_rsp(st, i, tbl_gen[i], tbl_handle[i], tbl_refs[i], 1'b1);
   endfunction

   // compute the results one request produces and update the shadow
   function automatic void predict_table(logic [1:0] cmd, logic [63:0] key,
         logic [31:0] size, logic [15:0] handle, logic [7:0] idx, logic [31:0] g);
      logic [31:0] room;
      int i;
      int n;
      logic [15:0] h;
      i = idx;
      case (cmd)
         CMD_UPLOAD: begin
            if (!alive) begin
               push_rsp(ST_STOPPED, 0, 0, NO_HANDLE, 0, 1'b1);
               return;
            end
            for (int k = 0; k < NSLOT; k++) begin
               if (tbl_refs[k] != 0 && tbl_key[k] == key) begin
                  if (tbl_refs[k] == 16'hFFFF) push_slot(ST_REF_LIMIT, k);
                  else begin
                     tbl_refs[k]++;
                     push_slot(ST_SHARED, k);
                  end
                  return;
               end
            end
            room = budget > bytes_used ? budget - bytes_used : 0;
            if (size > limit || size > room) begin
               push_rsp(ST_BUDGET, 0, 0, NO_HANDLE, 0, 1'b1);
               return;
            end
            n = NSLOT;
            for (int k = NSLOT - 1; k >= 0; k--) if (tbl_refs[k] == 0) n = k;
            if (n == NSLOT) begin
               push_rsp(ST_FULL, 0, 0, NO_HANDLE, 0, 1'b1);
               return;
            end
            if (handle == NO_HANDLE) begin
               push_rsp(ST_INVALID, 0, 0, NO_HANDLE, 0, 1'b1);
               return;
            end
            tbl_key[n] = key;
            tbl_gen[n] = gen_next;
            tbl_refs[n] = 1;
            tbl_size[n] = size;
            tbl_handle[n] = handle;
            bytes_used += size;
            gen_next = (gen_next == 32'hFFFF_FFFF) ? 32'd1 : gen_next + 1;
            push_slot(ST_NEW, n);
         end
         CMD_RELEASE: begin
            if (!alive || i >= NSLOT || tbl_refs[i] == 0 || tbl_gen[i] != g) begin
               push_rsp(ST_IGNORED, 0, 0, NO_HANDLE, 0, 1'b1);
               return;
            end
            tbl_refs[i]--;
            if (tbl_refs[i] != 0) begin
               push_slot(ST_SHARED, i);
               return;
            end
            h = tbl_handle[i];
            bytes_used -= tbl_size[i];
            tbl_size[i] = 0;
            tbl_handle[i] = NO_HANDLE;
            push_rsp(ST_FREED, i, tbl_gen[i], h, 0, 1'b1);
         end
         CMD_QUERY: begin
            if (!alive || i >= NSLOT)
               push_rsp(ST_INVALID, 0, 0, NO_HANDLE, 0, 1'b1);
            else if (tbl_refs[i] == 0 || tbl_gen[i] != g)
               push_rsp(ST_STALE, 0, 0, NO_HANDLE, 0, 1'b1);
            else
               push_slot(ST_SHARED, i);
         end
         default: begin
            if (!alive) begin
               push_rsp(ST_IGNORED, 0, 0, NO_HANDLE, 0, 1'b1);
               return;
            end
            // totals in the per-slot results are those after the stop
            bytes_used = 0;
            alive = 0;
            for (int k = 0; k < NSLOT; k++) begin
               tbl_size[k] = 0;
               if (tbl_refs[k] != 0) begin
                  h = tbl_handle[k];
                  tbl_handle[k] = NO_HANDLE;
                  tbl_refs[k] = 0;
                  push_rsp(ST_STOP_ENT, k, tbl_gen[k], h, 0, 1'b0);
               end
            end
            for (int k = 0; k < expected_rsp.size(); k++)
               if (expected_rsp[k].status == ST_STOP_ENT) expected_rsp[k].live = 0;
            push_rsp(ST_STOP_DONE, 0, 0, NO_HANDLE, 0, 1'b1);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      rsp_type got;
      if (reset) begin
         for (int k = 0; k < NSLOT; k++) begin
            tbl_key[k] = 0;
            tbl_gen[k] = 0;
            tbl_refs[k] = 0;
            tbl_size[k] = 0;
            tbl_handle[k] = NO_HANDLE;
         end
         bytes_used = 0;
         gen_next = 1;
         alive = 1;
         budget = 0;
         limit = SIZE_LIMIT_RESET;
         expected_rsp.delete();
      end else begin
         // register writes
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_LIMIT) limit = csr_pwdata;
            else budget = csr_pwdata;
         end
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_status, rsp_slot_index_res, rsp_generation_res,
                   rsp_gpu_handle_res, rsp_references, rsp_total_bytes,
                   rsp_live_count, rsp_last};
            if (expected_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result %h", $time, got);
            end else begin
               e = expected_rsp.pop_front();
               if (got !== e) begin
                  fail_count++;
                  $display("%0t: result mismatch expected %h actual %h", $time, e, got);
               end
            end
         end
         // request transfer
         if (req_valid && !req_stall)
            predict_table(req_command, req_key_hash, req_size_bytes, req_gpu_handle,
                          req_slot_index, req_generation);
      end
      pending = expected_rsp.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end
endmodule

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rht_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_command;
   logic [63:0] req_key_hash;
   logic [31:0] req_size_bytes;
   logic [15:0] req_gpu_handle;
   logic [7:0]  req_slot_index;
   logic [31:0] req_generation;
   logic        rsp_valid, rsp_stall;
   logic [3:0]  rsp_status;
   logic [4:0]  rsp_slot_index_res;
   logic [31:0] rsp_generation_res;
   logic [15:0] rsp_gpu_handle_res;
   logic [15:0] rsp_references;
   logic [31:0] rsp_total_bytes;
   logic [5:0]  rsp_live_count;
   logic        rsp_last;
   logic        csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   int          fail_count, pending;
   bit          stall_random;
   int          stall_left;

   // tokens handed out so far, used to build release and query requests
   logic [4:0]  tok_slot [$];
   logic [31:0] tok_gen [$];
   logic [63:0] key_pool [8];

   refcounted_handle_table_unit uut (.*);

   rht_checker chk (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("simulation failed");
      $finish;
   end

   // receiver side: short random stalls, now and then a long one
   always @(posedge clock) begin
      if (reset || !stall_random) begin
         rsp_stall <= 0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 2) begin
         rsp_stall <= 1;
         stall_left <= $urandom_range(10, 40);
      end else if ($urandom_range(0, 9) < 3) rsp_stall <= 1;
      else rsp_stall <= 0;
   end

   // record handed-out tokens
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall && rsp_status == ST_NEW) begin
         tok_slot.push_back(rsp_slot_index_res);
         tok_gen.push_back(rsp_generation_res);
      end
   end

   task automatic csr_write(logic [0:0] reg_idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
   endtask

   task automatic drain();
      do @(posedge clock); while (pending != 0 || rsp_valid);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_req(logic [1:0] cmd, logic [63:0] key, logic [31:0] size,
                           logic [15:0] handle, logic [7:0] idx, logic [31:0] g);
      int gap;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
      repeat (gap) @(posedge clock);
      req_valid <= 1;
      req_command <= cmd;
      req_key_hash <= key;
      req_size_bytes <= size;
      req_gpu_handle <= handle;
      req_slot_index <= idx;
      req_generation <= g;
      do @(posedge clock); while (req_stall);
      req_valid <= 0;
   endtask

   task automatic random_req();
      int pick, t;
      pick = $urandom_range(0, 99);
      t = tok_slot.size() ? $urandom_range(0, tok_slot.size() - 1) : 0;
      if (pick < 45)
         send_req(CMD_UPLOAD, key_pool[$urandom_range(0, 7)], $urandom_range(0, 300),
                  ($urandom_range(0, 19) == 0) ? NO_HANDLE : 16'($urandom),
                  8'($urandom), $urandom);
      else if (pick < 70 && tok_slot.size())
         send_req(CMD_RELEASE, {$urandom, $urandom}, $urandom, 16'($urandom),
                  {3'd0, tok_slot[t]}, tok_gen[t]);
      else if (pick < 88 && tok_slot.size())
         send_req(CMD_QUERY, {$urandom, $urandom}, $urandom, 16'($urandom),
                  {3'd0, tok_slot[t]}, ($urandom_range(0, 4) == 0) ? $urandom : tok_gen[t]);
      else
         send_req(2'($urandom_range(0, 2)), {$urandom, $urandom}, $urandom, 16'($urandom),
                  8'($urandom), $urandom);
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_command = 0;
      req_key_hash = 0;
      req_size_bytes = 0;
      req_gpu_handle = 0;
      req_slot_index = 0;
      req_generation = 0;
      csr_psel = 0;
      csr_penable = 0;
      csr_pwrite = 0;
      csr_paddr = 0;
      csr_pwdata = 0;
      stall_random = 0;
      for (int k = 0; k < 8; k++) key_pool[k] = {$urandom, $urandom};
      repeat (6) @(posedge clock);
      reset <= 0;
      repeat (2) @(posedge clock);

      // directed: budget zero, then extremes
      send_req(CMD_UPLOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1, 16'h1, 0, 0);
      send_req(CMD_UPLOAD, 64'h0, 0, 16'h0, 0, 0);
      send_req(CMD_UPLOAD, 64'h0, 0, 16'h5, 0, 0);
      send_req(CMD_QUERY, 0, 0, 0, 8'hFF, 32'hFFFF_FFFF);
      send_req(CMD_QUERY, 0, 0, 0, 0, 32'd1);
      send_req(CMD_QUERY, 0, 0, 0, 0, 32'd7);
      send_req(CMD_QUERY, 0, 0, 0, 5, 32'd1);
      send_req(CMD_RELEASE, 0, 0, 0, 8'hFF, 32'd1);
      drain();
      csr_write(REG_BUDGET, 32'hFFFF_FFFF);
      csr_write(REG_LIMIT, 32'd0);
      send_req(CMD_UPLOAD, 64'h1, 32'hFFFF_FFFF, 16'h2, 0, 0);
      send_req(CMD_UPLOAD, 64'h2, 0, NO_HANDLE, 0, 0);
      drain();
      csr_write(REG_LIMIT, 32'hFFFF_FFFF);
      send_req(CMD_UPLOAD, 64'h3, 32'hFFFF_FFFF, 16'hFFFE, 0, 0);
      send_req(CMD_UPLOAD, 64'h4, 1, 16'h3, 0, 0);
      send_req(CMD_RELEASE, 0, 0, 0, 0, 32'd1);
      // fill the table, then the last three uploads hit full
      for (int k = 0; k < 33; k++) send_req(CMD_UPLOAD, 64'h100 + k, 0, 16'(k), 0, 0);
      send_req(CMD_STOP, 0, 0, 0, 0, 0);
      send_req(CMD_STOP, 0, 0, 0, 0, 0);
      send_req(CMD_UPLOAD, 64'h7, 0, 16'h7, 0, 0);
      send_req(CMD_RELEASE, 0, 0, 0, 1, 32'd2);

      // random phases with different settings; reset is not repeated, so the
      // store stays stopped and these exercise the stopped paths with valid data
      stall_random = 1;
      drain();
      csr_write(REG_BUDGET, 32'd1000);
      csr_write(REG_LIMIT, 32'd200);
      for (int n = 0; n < 50; n++) random_req();
      drain();
      csr_write(REG_BUDGET, 32'd0);
      csr_write(REG_LIMIT, 32'd0);
      for (int n = 0; n < 50; n++) random_req();
      drain();

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

// File: filelist.f
rtl/rht_pkg.sv
rtl/refcounted_handle_table_unit.sv
tb/sv/rht_checker.sv
tb/sv/tb.sv
